// ===== rtl/core/ssdc_pkg.sv =====
// Package for the serial status display controller.
// Types, codes and segment tables shared by the front, queue and back modules.
package ssdc_pkg;

    localparam int LineMax = 31;
    localparam int LineW   = $clog2(LineMax + 1);

    // register indexes
    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_PACK    = 3'd1;
    localparam logic [2:0] REG_WASH    = 3'd2;
    localparam logic [2:0] REG_BLINK   = 3'd3;
    localparam logic [2:0] REG_YELLOW  = 3'd4;
    localparam logic [2:0] REG_RED     = 3'd5;

    // item kinds handed from front to back
    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_TICK  = 2'd1;
    localparam logic [1:0] K_PILLS = 2'd2;
    localparam logic [1:0] K_PROG  = 2'd3;

    localparam logic [6:0] SEG_DASH = 7'h40;
    localparam logic [6:0] SEG_C    = 7'h39;
    localparam logic [6:0] SEG_L    = 7'h38;
    localparam logic [6:0] SEG_E    = 7'h79;
    localparam logic [6:0] SEG_N    = 7'h54;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] value;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  seg0;
        logic [6:0]  seg1;
        logic [6:0]  seg2;
        logic [6:0]  seg3;
        logic [3:0]  lamps;
        logic        pack;
        logic        valve;
        logic        pulse;
        logic [15:0] batches;
    } t_res;

    function automatic logic [6:0] digit_seg(input logic [3:0] d);
        case (d)
            4'd0: digit_seg = 7'h3F;
            4'd1: digit_seg = 7'h06;
            4'd2: digit_seg = 7'h5B;
            4'd3: digit_seg = 7'h4F;
            4'd4: digit_seg = 7'h66;
            4'd5: digit_seg = 7'h6D;
            4'd6: digit_seg = 7'h7D;
            4'd7: digit_seg = 7'h07;
            4'd8: digit_seg = 7'h7F;
            4'd9: digit_seg = 7'h6F;
            default: digit_seg = 7'h00;
        endcase
    endfunction

    // tens digit of a value below 100: multiply by 205, take bits 14:11
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        tens_of = p[14:11];
    endfunction

    // ones digit of a value below 100: subtract ten times the tens digit
    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [3:0] t;
        logic [6:0] t10;
        logic [6:0] rem;
        t       = tens_of(v);
        t10     = {t, 3'b000} + {2'b00, t, 1'b0};
        rem     = v - t10;
        ones_of = rem[3:0];
    endfunction

    function automatic logic [7:0] prefix_char(input logic [3:0] pm);
        case (pm)
            4'd2:  prefix_char = "L";
            4'd3:  prefix_char = "L";
            4'd4:  prefix_char = "S";
            4'd5:  prefix_char = ":";
            4'd7:  prefix_char = "O";
            4'd8:  prefix_char = "G";
            4'd9:  prefix_char = "R";
            4'd10: prefix_char = "E";
            4'd11: prefix_char = "S";
            4'd12: prefix_char = "S";
            4'd13: prefix_char = ":";
            default: prefix_char = 8'h00;
        endcase
    endfunction

endpackage

// ===== rtl/core/ssdc_front.sv =====
// Front end: line parser for received bytes; classifies each beat.
// Depends on ssdc_pkg.
module ssdc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_mode,
    input  logic [7:0]     i_rx_byte,
    output ssdc_pkg::t_cmd o_cmd
);
    import ssdc_pkg::*;

    localparam logic [3:0] PM_PILLS_DONE = 4'd6;
    localparam logic [3:0] PM_PROG_FIRST = 4'd7;
    localparam logic [3:0] PM_PROG_DONE  = 4'd14;
    localparam logic [3:0] PM_DEAD       = 4'd15;
    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    logic [LineW-1:0] r_len, n_len;
    logic [3:0] r_pm, n_pm;
    logic [1:0] r_ph, n_ph;
    logic r_neg, n_neg;
    logic [9:0] r_val, n_val;
    logic [13:0] prod;
    logic digit, blank;
    logic [3:0] dv;

    assign dv    = i_rx_byte[3:0] - 4'd0;
    assign digit = (i_rx_byte >= "0") && (i_rx_byte <= "9");
    assign blank = (i_rx_byte == " ") || (i_rx_byte == 8'h09) || (i_rx_byte == 8'h0B)
                || (i_rx_byte == 8'h0C);
    assign prod  = {4'd0, r_val} * 14'd10 + {10'd0, dv};

    // parse one byte; classify the beat
    always_comb begin
        n_len = r_len; n_pm = r_pm; n_ph = r_ph; n_neg = r_neg; n_val = r_val;
        o_cmd.kind  = i_mode ? K_TICK : K_BYTE;
        o_cmd.value = r_val;
        if (!i_mode) begin
            if (i_rx_byte == 8'h0A) begin
                if (r_pm == PM_PILLS_DONE && (!r_neg || r_val == 10'd0)
                        && r_val <= 10'd999) begin
                    o_cmd.kind = K_PILLS;
                end else if (r_pm == PM_PROG_DONE && (!r_neg || r_val == 10'd0)
                        && r_val <= 10'd100) begin
                    o_cmd.kind = K_PROG;
                end
                n_len = '0; n_pm = '0; n_ph = PH_BEFORE; n_neg = 1'b0; n_val = '0;
            end else if (i_rx_byte != 8'h0D) begin
                if (r_len < LineW'(LineMax)) begin
                    n_len = r_len + 1'b1;
                    if (r_pm == PM_PILLS_DONE || r_pm == PM_PROG_DONE) begin
                        if (r_ph == PH_BEFORE && blank) begin
                            n_ph = r_ph;
                        end else if (r_ph == PH_BEFORE && i_rx_byte == "+") begin
                            n_ph = PH_SIGN;
                        end else if (r_ph == PH_BEFORE && i_rx_byte == "-") begin
                            n_ph = PH_SIGN; n_neg = 1'b1;
                        end else if (r_ph == PH_BEFORE || r_ph == PH_SIGN) begin
                            if (digit) begin
                                n_val = {6'd0, dv}; n_ph = PH_DIGITS;
                            end else begin
                                n_ph = PH_END;
                            end
                        end else if (r_ph == PH_DIGITS) begin
                            if (digit) begin
                                n_val = (prod > 14'd1023) ? 10'd1023 : prod[9:0];
                            end else begin
                                n_ph = PH_END;
                            end
                        end
                    end else if (r_pm == 4'd0) begin
                        n_pm = (i_rx_byte == "P") ? 4'd1 : PM_DEAD;
                    end else if (r_pm == 4'd1) begin
                        n_pm = (i_rx_byte == "I") ? 4'd2
                             : (i_rx_byte == "R") ? PM_PROG_FIRST : PM_DEAD;
                    end else if (r_pm == PM_DEAD) begin
                        n_pm = PM_DEAD;
                    end else begin
                        n_pm = (i_rx_byte == prefix_char(r_pm)) ? r_pm + 4'd1 : PM_DEAD;
                    end
                end else begin
                    n_len = '0; n_pm = '0; n_ph = PH_BEFORE; n_neg = 1'b0; n_val = '0;
                end
            end
        end
    end

    // advance parser on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_pm <= '0; r_ph <= PH_BEFORE; r_neg <= 1'b0; r_val <= '0;
        end else if (i_valid) begin
            r_len <= n_len; r_pm <= n_pm; r_ph <= n_ph; r_neg <= n_neg; r_val <= n_val;
        end
    end

`ifndef SYNTH
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LineW'(LineMax)) else $error("line length overrun");
    a_ph_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pm != PM_PILLS_DONE && r_pm != PM_PROG_DONE) |-> (r_ph == PH_BEFORE))
        else $error("number phase moved outside number field");
    a_val_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_BEFORE) |-> (r_val == 10'd0)) else $error("stale number value");
`endif
endmodule

// ===== rtl/core/ssdc_queue.sv =====
// Two-entry queue between front and back; registers for both sides.
// Depends on ssdc_pkg.
module ssdc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssdc_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output ssdc_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import ssdc_pkg::*;

    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];

    // hold payload at write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTH
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
`endif
endmodule

// ===== rtl/core/ssdc_back.sv =====
// Back end: modes, timers, lamps and display; single output register.
// Depends on ssdc_pkg.
module ssdc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ssdc_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic [15:0]    i_idle_limit_ms,
    input  logic [13:0]    i_pack_ms,
    input  logic [13:0]    i_wash_ms,
    input  logic [9:0]     i_blink_half_ms,
    input  logic [6:0]     i_yellow_from,
    input  logic [6:0]     i_red_from,
    output logic           o_valid,
    input  logic           i_stall,
    output ssdc_pkg::t_res o_res
);
    import ssdc_pkg::*;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_CLEAN   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    logic [1:0]  r_st, n_st;
    logic [9:0]  r_pills, n_pills;
    logic [6:0]  r_prog, n_prog;
    logic [15:0] r_since, n_since;
    logic [13:0] r_el, n_el;
    logic [9:0]  r_blink, n_blink;
    logic [3:0]  r_lamps, n_lamps;
    logic [15:0] r_batches, n_batches;
    t_res        res;
    t_res        r_out;
    logic        r_out_v;
    logic [6:0]  l_mod, p_mod;
    logic [9:0]  l_bin;
    logic [9:0]  upd_pills;
    logic [6:0]  upd_prog;
    logic [13:0] longest;

    assign o_pop   = i_valid && (!r_out_v || !i_stall);
    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign longest = (i_pack_ms > i_wash_ms) ? i_pack_ms : i_wash_ms;

    // counts after this beat's line update
    assign upd_pills = (i_cmd.kind == K_PILLS) ? i_cmd.value : r_pills;
    assign upd_prog  = (i_cmd.kind == K_PROG) ? i_cmd.value[6:0] : r_prog;

    // pill count mod 100 by compare and subtract (below 1000); progress likewise
    always_comb begin
        l_bin = upd_pills;
        if (l_bin >= 10'd800) l_bin = l_bin - 10'd800;
        if (l_bin >= 10'd400) l_bin = l_bin - 10'd400;
        if (l_bin >= 10'd200) l_bin = l_bin - 10'd200;
        if (l_bin >= 10'd100) l_bin = l_bin - 10'd100;
        l_mod = l_bin[6:0];
        p_mod = (upd_prog >= 7'd100) ? upd_prog - 7'd100 : upd_prog;
    end

    // evaluate one beat
    always_comb begin
        logic [9:0] nb;
        nb = '0;
        n_st = r_st; n_pills = r_pills; n_prog = r_prog; n_since = r_since;
        n_el = r_el; n_blink = r_blink; n_lamps = r_lamps; n_batches = r_batches;
        res = '0;
        case (i_cmd.kind)
            K_PILLS: begin n_pills = i_cmd.value; n_since = '0; end
            K_PROG:  begin n_prog = i_cmd.value[6:0]; n_since = '0; end
            K_BYTE:  n_since = '0;
            K_TICK: begin
                if (r_since != 16'hFFFF) n_since = r_since + 16'd1;
                if (r_st == ST_CLEAN && r_el != 14'h3FFF) n_el = r_el + 14'd1;
                if (r_prog >= 7'd100) begin
                    nb = r_blink + 10'd1;
                    if (nb >= i_blink_half_ms) begin
                        n_lamps[3] = ~r_lamps[3]; nb = '0;
                    end
                    n_blink = nb;
                end else begin
                    n_lamps[3] = 1'b0; n_blink = '0;
                end
            end
            default: ;
        endcase
        if (n_since > i_idle_limit_ms) n_st = ST_TIMEOUT;
        res.seg0 = digit_seg(tens_of(l_mod));
        res.seg1 = digit_seg(ones_of(l_mod));
        res.seg2 = digit_seg(tens_of(p_mod));
        res.seg3 = digit_seg(ones_of(p_mod));
        if (n_st == ST_TIMEOUT) begin
            res.seg0 = SEG_DASH; res.seg1 = SEG_DASH; res.seg2 = SEG_DASH;
            res.seg3 = SEG_DASH;
            n_lamps[2:0] = 3'b100;
            if (n_since <= i_idle_limit_ms) n_st = ST_RUN;
        end else if (n_st == ST_CLEAN) begin
            res.valve = n_el < i_wash_ms;
            res.pack  = n_el < i_pack_ms;
            res.seg0 = SEG_C; res.seg1 = SEG_L; res.seg2 = SEG_E; res.seg3 = SEG_N;
            n_lamps[2:0] = 3'b000;
            if (n_el >= longest) begin
                n_st = ST_RUN; n_pills = '0; n_prog = '0;
                n_batches = r_batches + 16'd1;
                res.pack = 1'b0; res.valve = 1'b0;
                n_lamps[2:0] = 3'b001;
                res.seg0 = digit_seg(4'd0); res.seg1 = digit_seg(4'd0);
                res.seg2 = digit_seg(4'd0); res.seg3 = digit_seg(4'd0);
            end
        end else begin
            n_st = ST_RUN;
            if (n_prog < i_yellow_from)   n_lamps[2:0] = 3'b001;
            else if (n_prog < i_red_from) n_lamps[2:0] = 3'b010;
            else if (n_prog < 7'd100)     n_lamps[2:0] = 3'b100;
            if (n_prog >= 7'd100) begin
                n_st = ST_CLEAN; n_el = '0; res.pulse = 1'b1;
            end
        end
        res.lamps   = n_lamps;
        res.batches = n_batches;
    end

    // commit state and load output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RUN; r_pills <= '0; r_prog <= '0; r_since <= '0; r_el <= '0;
            r_blink <= '0; r_lamps <= '0; r_batches <= '0; r_out_v <= 1'b0;
        end else begin
            if (o_pop) begin
                r_st <= n_st; r_pills <= n_pills; r_prog <= n_prog; r_since <= n_since;
                r_el <= n_el; r_blink <= n_blink; r_lamps <= n_lamps;
                r_batches <= n_batches;
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_out <= res;
    end

`ifndef SYNTH
    a_pulse_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && res.pulse) |=> (r_st == ST_CLEAN)) else $error("pulse without clean");
    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= 7'd100) else $error("progress out of range");
    a_batch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_batches != $past(r_batches)) |-> ($past(r_st) == ST_CLEAN))
        else $error("batch counted outside cleaning");
`endif
endmodule

// ===== rtl/core/serial_status_display_controller.sv =====
// Top level of the serial status display controller.
// Depends on ssdc_pkg, ssdc_front, ssdc_queue, ssdc_back.
//
//  channel | direction | handshake            | payload
//  in      | input     | i_valid / o_stall    | i_mode, i_rx_byte
//  out     | output    | o_valid / i_stall    | o_seg_digit0..3, lamps, outputs, count
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One beat per cycle while o_stall is low; the accepting edge parses and writes the queue,
// and the beat is evaluated into the output register when popped, where it is offered.
// Synchronous active-low reset restores the register defaults and run mode.
// Output stalls fill the two-entry queue, after which o_stall rises.
module serial_status_display_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_seg_digit0,
    output logic [6:0]  o_seg_digit1,
    output logic [6:0]  o_seg_digit2,
    output logic [6:0]  o_seg_digit3,
    output logic        o_led_green,
    output logic        o_led_yellow,
    output logic        o_led_red,
    output logic        o_led_blue,
    output logic        o_pack_on,
    output logic        o_valve_on,
    output logic        o_send_reset,
    output logic [15:0] o_batch_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ssdc_pkg::*;

    logic [15:0] r_timeout;
    logic [13:0] r_pack, r_wash;
    logic [9:0]  r_blink;
    logic [6:0]  r_yellow, r_red;
    t_cmd f_cmd, q_cmd;
    t_res res;
    logic q_full, q_valid, pop, acc;

    assign o_stall = q_full;
    assign acc     = i_valid && !q_full;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd30000; r_pack <= 14'd5000; r_wash <= 14'd3000;
            r_blink <= 10'd125; r_yellow <= 7'd50; r_red <= 7'd90;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                REG_PACK:    r_pack    <= i_cfg_data[13:0];
                REG_WASH:    r_wash    <= i_cfg_data[13:0];
                REG_BLINK:   r_blink   <= i_cfg_data[9:0];
                REG_YELLOW:  r_yellow  <= i_cfg_data[6:0];
                REG_RED:     r_red     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ssdc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc),
        .i_mode(i_mode), .i_rx_byte(i_rx_byte), .o_cmd(f_cmd)
    );

    ssdc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(acc), .i_cmd(f_cmd),
        .o_full(q_full), .o_valid(q_valid), .o_cmd(q_cmd), .i_pop(pop)
    );

    ssdc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .i_idle_limit_ms(r_timeout), .i_pack_ms(r_pack), .i_wash_ms(r_wash),
        .i_blink_half_ms(r_blink), .i_yellow_from(r_yellow), .i_red_from(r_red),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(res)
    );

    assign o_seg_digit0  = res.seg0;
    assign o_seg_digit1  = res.seg1;
    assign o_seg_digit2  = res.seg2;
    assign o_seg_digit3  = res.seg3;
    assign o_led_green   = res.lamps[0];
    assign o_led_yellow  = res.lamps[1];
    assign o_led_red     = res.lamps[2];
    assign o_led_blue    = res.lamps[3];
    assign o_pack_on     = res.pack;
    assign o_valve_on    = res.valve;
    assign o_send_reset  = res.pulse;
    assign o_batch_count = res.batches;
endmodule
